// ===== hdl/sbpq_pkg.sv =====
// Shared types, codes and defaults for the score bucket priority queue.
package sbpq_pkg;

	localparam int NUM_BUCKETS_DEF = 256;
	localparam int CAPACITY_DEF    = 1024;

	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_EXTRACT = 2'd1;
	localparam logic [1:0] MODE_FIND    = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] block_id;
		logic [31:0] score;
	} op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] block_id;
		logic [31:0] score;
	} res_t;

endpackage

// ===== hdl/sbpq_div.sv =====
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module sbpq_div
	import sbpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo
);
	logic [31:0] rem_q;
	logic [31:0] qr_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	// Form one trial subtraction
	always_comb begin
		shifted = {rem_q, qr_q[31]};
		trial   = shifted - {1'b0, den_q};
	end

	assign quo = qr_q;

	// Step the remainder and quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (cnt_q == 6'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qr_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				qr_q  <= {qr_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				qr_q  <= {qr_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/sbpq_front.sv =====
// Front end: accepts operations, works out the bucket of adds, queues them.
module sbpq_front
	import sbpq_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  op_t           op_in,
	input  logic [31:0]   range_lo,
	input  logic [31:0]   range_hi,
	output logic          q_valid,
	input  logic          q_pop,
	output op_t           q_op,
	output logic [BW-1:0] q_bucket
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_WDIV = 2'd1;
	localparam logic [1:0] F_IDIV = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	// reciprocal of the bucket count, exact for every 32-bit span
	localparam logic [64:0] RECIP =
		65'(((64'd1 << (32 + BW)) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS));

	logic [1:0]    state_q;
	op_t           op_q;
	logic [BW-1:0] bkt_q;
	logic          div_start;
	logic [31:0]   div_num;
	logic [31:0]   div_den;
	logic          div_done;
	logic [31:0]   div_quo;
	logic [31:0]   offs;
	logic [31:0]   span_w;
	logic [64:0]   wprod;
	logic [31:0]   wq;
	logic [31:0]   wid_w;
	logic [BW-1:0] bkt_clamp;
	logic          accept;

	op_t           qop_q [2];
	logic [BW-1:0] qbk_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    qcnt_q;
	logic          q_full;
	logic          q_wr;

	sbpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;
	assign offs   = op_q.score - range_lo;
	assign q_full = (qcnt_q == 2'd2);
	assign q_wr   = (state_q == F_PUSH) && !q_full;

	// Bucket width from the score range, raised to one
	assign span_w = range_hi - range_lo;
	assign wprod  = 65'(span_w) * RECIP;
	assign wq     = 32'(wprod >> (32 + BW));
	assign wid_w  = (wq == 32'd0) ? 32'd1 : wq;

	// Clamp a quotient to the top bucket
	function automatic logic [BW-1:0] clamp_bkt(input logic [31:0] q);
		logic [BW-1:0] r;
		if (q >= 32'(NUM_BUCKETS))
			r = BW'(NUM_BUCKETS - 1);
		else
			r = q[BW-1:0];
		return r;
	endfunction

	assign bkt_clamp = clamp_bkt(div_quo);

	// Launch the divider for the index
	always_comb begin
		div_start = (state_q == F_WDIV);
		div_num   = offs;
		div_den   = wid_w;
	end

	// Sequence one operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (op_in.mode != MODE_ADD)
							state_q <= F_PUSH;
						else if (range_hi > range_lo)
							state_q <= F_WDIV;
						else
							state_q <= F_PUSH;
					end
				end
				F_WDIV: begin
					state_q <= F_IDIV;
				end
				F_IDIV: begin
					if (div_done)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Hold the operation and its bucket
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			bkt_q <= clamp_bkt(op_in.score - range_lo);
		end else if (state_q == F_IDIV && div_done) begin
			bkt_q <= bkt_clamp;
		end
	end

	// Queue towards the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			qcnt_q <= '0;
		end else begin
			if (q_wr)
				wp_q <= ~wp_q;
			if (q_pop && q_valid)
				rp_q <= ~rp_q;
			qcnt_q <= qcnt_q + 2'(q_wr) - 2'(q_pop && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr) begin
			qop_q[wp_q] <= op_q;
			qbk_q[wp_q] <= bkt_q;
		end
	end

	assign q_valid  = (qcnt_q != 2'd0);
	assign q_op     = qop_q[rp_q];
	assign q_bucket = qbk_q[rp_q];

endmodule

// ===== hdl/sbpq_engine.sv =====
// Back end: bucket lists, slot store and free-slot stack.
module sbpq_engine
	import sbpq_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int CAPACITY    = CAPACITY_DEF,
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  op_t           q_op,
	input  logic [BW-1:0] q_bucket,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res
);
	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int NBP = ((NUM_BUCKETS + 7) / 8) * 8;
	localparam int CBW = $clog2(NBP);

	localparam logic [2:0] E_IDLE   = 3'd0;
	localparam logic [2:0] E_ADD_RD = 3'd1;
	localparam logic [2:0] E_ADD_WR = 3'd2;
	localparam logic [2:0] E_SCAN   = 3'd3;
	localparam logic [2:0] E_HT     = 3'd4;
	localparam logic [2:0] E_CHK    = 3'd5;
	localparam logic [2:0] E_RES    = 3'd6;

	logic [2:0]             state_q;
	op_t                    op_q;
	logic [BW-1:0]          b_q;
	logic [CBW-1:0]         cb_q;
	logic                   ext_q;
	logic [AW-1:0]          slot_q;
	logic [AW-1:0]          prev_q;
	logic                   hasp_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          hwm_q;
	logic [NUM_BUCKETS-1:0] ne_q;
	res_t                   res_q;

	logic [63:0]    en_mem [CAPACITY];
	logic [AW-1:0]  nx_mem [CAPACITY];
	logic [AW-1:0]  fl_mem [CAPACITY];
	logic [AW-1:0]  hd_mem [NUM_BUCKETS];
	logic [AW-1:0]  tl_mem [NUM_BUCKETS];
	logic [63:0]    en_rd;
	logic [AW-1:0]  nx_rd;
	logic [AW-1:0]  fl_rd;
	logic [AW-1:0]  hd_rd;
	logic [AW-1:0]  tl_rd;

	logic           en_we, nx_we, fl_we, hd_we, tl_we;
	logic           en_re, fl_re, hd_re, tl_re;
	logic [AW-1:0]  en_ra, fl_ra;
	logic [BW-1:0]  hd_ra;
	logic [AW-1:0]  en_wa, nx_wa, fl_wa;
	logic [BW-1:0]  hd_wa, tl_wa;
	logic [AW-1:0]  nx_wd, fl_wd, hd_wd, tl_wd;

	logic [NBP-1:0] ne_pad;
	logic [CBW-1:0] gbase;
	logic [7:0]     grp;
	logic [2:0]     pos;
	logic           hit;
	logic [CBW-1:0] hit_b;
	logic [AW-1:0]  slot_new;
	logic           match;
	logic           is_tail;

	// Group scan of the non-empty bits, eight buckets a cycle
	always_comb begin
		ne_pad = '0;
		ne_pad[NUM_BUCKETS-1:0] = ne_q;
		gbase = cb_q & ~CBW'(7);
		grp   = ne_pad[gbase +: 8];
		pos   = '0;
		hit   = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (grp[i] && (3'(i) <= cb_q[2:0])) begin
				pos = 3'(i);
				hit = 1'b1;
			end
		end
		hit_b = gbase + CBW'(pos);
	end

	assign slot_new = (cnt_q < hwm_q) ? fl_rd : cnt_q[AW-1:0];
	assign match    = ext_q || (en_rd[63:32] == op_q.block_id);
	assign is_tail  = (slot_q == tl_rd);
	assign q_pop    = (state_q == E_IDLE) && q_valid;
	assign res_valid = (state_q == E_RES);
	assign res       = res_q;

	// Drive memory ports
	always_comb begin
		en_we = 1'b0; nx_we = 1'b0; fl_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
		en_re = 1'b0; fl_re = 1'b0; hd_re = 1'b0; tl_re = 1'b0;
		en_ra = nx_rd; fl_ra = cnt_q[AW-1:0]; hd_ra = hit_b[BW-1:0];
		en_wa = slot_new; nx_wa = tl_rd; fl_wa = AW'(cnt_q - CW'(1));
		hd_wa = b_q; tl_wa = b_q;
		nx_wd = slot_new; fl_wd = slot_q; hd_wd = slot_new; tl_wd = slot_new;
		unique case (state_q)
			E_ADD_RD: begin
				fl_re = 1'b1;
				tl_re = 1'b1;
				hd_ra = b_q;
			end
			E_ADD_WR: begin
				en_we = 1'b1;
				tl_we = 1'b1;
				if (ne_q[b_q])
					nx_we = 1'b1;
				else
					hd_we = 1'b1;
			end
			E_SCAN: begin
				hd_re = hit;
				tl_re = hit;
			end
			E_HT: begin
				en_re = 1'b1;
				en_ra = hd_rd;
			end
			E_CHK: begin
				if (match) begin
					fl_we = 1'b1;
					if (!hasp_q) begin
						hd_we = !is_tail;
						hd_wd = nx_rd;
					end else begin
						nx_we = 1'b1;
						nx_wa = prev_q;
						nx_wd = nx_rd;
						tl_we = is_tail;
						tl_wd = prev_q;
					end
				end else if (!is_tail) begin
					en_re = 1'b1;
				end
			end
			default: begin
				en_re = 1'b0;
			end
		endcase
	end

	// Slot store and link memory
	always_ff @(posedge clk) begin
		if (en_we)
			en_mem[en_wa] <= {op_q.block_id, op_q.score};
		if (en_re)
			en_rd <= en_mem[en_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we)
			nx_mem[nx_wa] <= nx_wd;
		if (en_re)
			nx_rd <= nx_mem[en_ra];
	end

	always_ff @(posedge clk) begin
		if (fl_we)
			fl_mem[fl_wa] <= fl_wd;
		if (fl_re)
			fl_rd <= fl_mem[fl_ra];
	end

	// Bucket head and tail memories
	always_ff @(posedge clk) begin
		if (hd_we)
			hd_mem[hd_wa] <= hd_wd;
		if (hd_re)
			hd_rd <= hd_mem[hd_ra];
	end

	always_ff @(posedge clk) begin
		if (tl_we)
			tl_mem[tl_wa] <= tl_wd;
		if (tl_re)
			tl_rd <= tl_mem[hd_ra];
	end

	// Sequence one operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q   <= '0;
			hwm_q   <= '0;
			ne_q    <= '0;
		end else begin
			unique case (state_q)
				E_IDLE: begin
					if (q_valid) begin
						if (q_op.mode == MODE_ADD) begin
							if (cnt_q >= CW'(CAPACITY))
								state_q <= E_RES;
							else
								state_q <= E_ADD_RD;
						end else if (q_op.mode == MODE_EXTRACT || q_op.mode == MODE_FIND) begin
							state_q <= E_SCAN;
						end else begin
							state_q <= E_RES;
						end
					end
				end
				E_ADD_RD: state_q <= E_ADD_WR;
				E_ADD_WR: begin
					ne_q[b_q] <= 1'b1;
					cnt_q     <= cnt_q + CW'(1);
					if (cnt_q == hwm_q)
						hwm_q <= hwm_q + CW'(1);
					state_q <= E_RES;
				end
				E_SCAN: begin
					if (hit)
						state_q <= E_HT;
					else if (gbase == '0)
						state_q <= E_RES;
				end
				E_HT: state_q <= E_CHK;
				E_CHK: begin
					if (match) begin
						if (!hasp_q && is_tail)
							ne_q[b_q] <= 1'b0;
						cnt_q   <= cnt_q - CW'(1);
						state_q <= E_RES;
					end else if (is_tail) begin
						if (b_q == '0)
							state_q <= E_RES;
						else
							state_q <= E_SCAN;
					end
				end
				E_RES: begin
					if (res_ready)
						state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			E_IDLE: begin
				op_q   <= q_op;
				b_q    <= q_bucket;
				cb_q   <= CBW'(NUM_BUCKETS - 1);
				ext_q  <= (q_op.mode == MODE_EXTRACT);
				res_q  <= '{status: (q_op.mode == MODE_ADD && cnt_q >= CW'(CAPACITY)) ?
						ST_FULL : ST_EMPTY,
					block_id: 32'd0, score: 32'd0};
			end
			E_ADD_WR: begin
				res_q.status <= ST_DONE;
			end
			E_SCAN: begin
				if (hit)
					b_q <= hit_b[BW-1:0];
				else
					cb_q <= gbase - CBW'(1);
			end
			E_HT: begin
				slot_q <= hd_rd;
				hasp_q <= 1'b0;
			end
			E_CHK: begin
				if (match) begin
					res_q <= '{status: ST_DONE, block_id: en_rd[63:32], score: en_rd[31:0]};
				end else if (is_tail) begin
					cb_q <= CBW'(b_q) - CBW'(1);
				end else begin
					prev_q <= slot_q;
					hasp_q <= 1'b1;
					slot_q <= nx_rd;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule

// ===== hdl/score_bucket_priority_queue.sv =====
// Top level of the score bucket priority queue: config registers and result register.
// Usage
//   Operations enter on push/full as (mode, block_id, score); a beat is taken when
//   push is high and full is low. Each operation yields exactly one result beat
//   (status, out_block_id, out_score), shown while empty is low and taken on pop.
//   The low and high score registers sit at byte 0 and 4 of the APB port; write
//   them only while the queue is idle. They are read back on prdata.
// Flow
//   When high > low the front end forms the bucket width by a reciprocal multiply
//   and the index with a one-bit-a-cycle divider; full stays high until the add is
//   written into the queue, as it does for other adds and the other modes. The back
//   end reads the free slot and tail and then writes for an add, group-scans the
//   non-empty bits for an extract, and for a find walks each bucket's list after the
//   scan. A two-deep queue lets the two sides overlap.
// Reset
//   arst_n empties the queue; the free-slot stack is tracked by a high-water
//   count, so no clearing pass is needed and items are taken at once.
// Stall
//   A result not popped holds in the output register; the back end then waits,
//   the queue fills, and full stays high.
module score_bucket_priority_queue
	import sbpq_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int CAPACITY    = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [31:0] block_id,
	input  logic [31:0] score,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [31:0] out_block_id,
	output logic [31:0] out_score,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	logic [31:0]   min_q;
	logic [31:0]   max_q;
	op_t           op_in;
	logic          q_valid;
	logic          q_pop;
	op_t           q_op;
	logic [BW-1:0] q_bucket;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          out_valid_q;
	res_t          out_q;

	assign op_in = '{mode: mode, block_id: block_id, score: score};

	sbpq_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op_in     (op_in),
		.range_lo  (min_q),
		.range_hi  (max_q),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_op      (q_op),
		.q_bucket  (q_bucket)
	);

	sbpq_engine #(.NUM_BUCKETS(NUM_BUCKETS), .CAPACITY(CAPACITY)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_op      (q_op),
		.q_bucket  (q_bucket),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Configuration registers
	assign pready = 1'b1;
	assign prdata = paddr[2] ? max_q : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 32'hFFFF_FFFF;
			max_q <= 32'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2])
				max_q <= pwdata;
			else
				min_q <= pwdata;
		end
	end

	// Hold the result beat until popped
	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign empty        = !out_valid_q;
	assign status       = out_q.status;
	assign out_block_id = out_q.block_id;
	assign out_score    = out_q.score;

endmodule

// ===== sim/sbpq_checker.sv =====
// Checker for the score bucket priority queue: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module sbpq_checker
	import sbpq_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int CAPACITY    = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  mode,
	input  logic [31:0] block_id,
	input  logic [31:0] score,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [31:0] out_block_id,
	input  logic [31:0] out_score,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          full_seen
);

	localparam logic [2:0] ADDR_MIN = 3'd0;
	localparam logic [2:0] ADDR_MAX = 3'd4;

	logic [31:0] min_reg;
	logic [31:0] max_reg;
	// each bucket holds {block id, score} beats in arrival order
	logic [63:0] bucket_q [NUM_BUCKETS][$];
	int          stored;
	res_t        expected_q [$];

	function automatic int bucket_index(logic [31:0] sc);
		logic [31:0] width;
		logic [31:0] idx;
		width = 32'd1;
		if (max_reg > min_reg) begin
			width = (max_reg - min_reg) / 32'(NUM_BUCKETS);
			if (width == 32'd0)
				width = 32'd1;
		end
		idx = (sc - min_reg) / width;
		if (idx >= 32'(NUM_BUCKETS))
			idx = 32'(NUM_BUCKETS - 1);
		return int'(idx);
	endfunction

	function automatic res_t predict_result(logic [1:0] md, logic [31:0] id, logic [31:0] sc);
		res_t r;
		int   b;
		bit   found;
		r = '{status: ST_EMPTY, block_id: 32'd0, score: 32'd0};
		found = 1'b0;
		case (md)
			MODE_ADD: begin
				if (stored >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					b = bucket_index(sc);
					bucket_q[b].push_back({id, sc});
					stored++;
					r.status = ST_DONE;
				end
			end
			MODE_EXTRACT: begin
				for (b = NUM_BUCKETS - 1; b >= 0 && !found; b--) begin
					if (bucket_q[b].size() != 0) begin
						{r.block_id, r.score} = bucket_q[b].pop_front();
						r.status = ST_DONE;
						stored--;
						found = 1'b1;
					end
				end
			end
			MODE_FIND: begin
				for (b = NUM_BUCKETS - 1; b >= 0 && !found; b--) begin
					for (int k = 0; k < bucket_q[b].size() && !found; k++) begin
						if (bucket_q[b][k][63:32] == id) begin
							{r.block_id, r.score} = bucket_q[b][k];
							bucket_q[b].delete(k);
							r.status = ST_DONE;
							stored--;
							found = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			min_reg = 32'hFFFF_FFFF;
			max_reg = 32'd0;
			stored = 0;
			fail_count = 0;
			results_seen = 0;
			full_seen = 0;
			expected_q.delete();
			for (int b = 0; b < NUM_BUCKETS; b++)
				bucket_q[b].delete();
			pending = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_MIN)
					min_reg = pwdata;
				else if (paddr == ADDR_MAX)
					max_reg = pwdata;
			end
			// predict on every accepted operation beat
			if (push && !full) begin
				want = predict_result(mode, block_id, score);
				if (want.status == ST_FULL)
					full_seen++;
				expected_q.push_back(want);
			end
			// compare every accepted result beat with the oldest prediction
			if (pop && !empty) begin
				got = '{status: status, block_id: out_block_id, score: out_score};
				results_seen++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: result beat with nothing expected: st=%0d id=%h sc=%h",
							got.status, got.block_id, got.score);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("ERROR: result %0d: exp st=%0d id=%h sc=%h, got st=%0d id=%h sc=%h",
								results_seen, want.status, want.block_id, want.score,
								got.status, got.block_id, got.score);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the testbench: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
	import sbpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 30000;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int FILL_ITEMS = 1030;
	localparam logic [2:0] ADDR_MIN = 3'd0;
	localparam logic [2:0] ADDR_MAX = 3'd4;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  mode;
	logic [31:0] block_id;
	logic [31:0] score;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [31:0] out_block_id;
	logic [31:0] out_score;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int results_seen;
	int full_seen;
	int items_sent;
	int idle_cycles;
	int pop_wait;
	bit pop_hit;
	bit quiet;
	logic [31:0] cur_min;
	logic [31:0] cur_max;

	score_bucket_priority_queue dut (.*);

	sbpq_checker u_checker (
		.clk, .arst_n, .push, .full, .mode, .block_id, .score, .empty, .pop,
		.status, .out_block_id, .out_score, .psel, .penable, .pwrite, .paddr,
		.pwdata, .pready, .fail_count, .pending, .results_seen, .full_seen
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// note each result beat taken
	always @(posedge clk) begin
		pop_hit <= arst_n && pop && !empty;
	end

	// drain results with a random hold-off per beat
	always @(negedge clk) begin
		int w;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_wait <= 0;
		end else if (pop_hit) begin
			w = quiet ? 0 : $urandom_range(0, 13);
			pop <= (w == 0);
			pop_wait <= (w > 0) ? w - 1 : 0;
		end else if (pop_wait > 0) begin
			pop <= 1'b0;
			pop_wait <= pop_wait - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_op(logic [1:0] md, logic [31:0] id, logic [31:0] sc);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		mode <= md;
		block_id <= id;
		score <= sc;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		items_sent++;
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(negedge clk);
		push <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait for every result, then set a new score range
	task automatic set_range(logic [31:0] lo, logic [31:0] hi);
		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		reg_write(ADDR_MIN, lo);
		reg_write(ADDR_MAX, hi);
		cur_min = lo;
		cur_max = hi;
	endtask

	function automatic logic [31:0] pick_id();
		return ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 40));
	endfunction

	function automatic logic [31:0] pick_score();
		logic [31:0] span;
		span = (cur_max > cur_min) ? cur_max - cur_min : 32'd600;
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return cur_min;
			2: return cur_max;
			3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
			default: return cur_min + 32'(33'($urandom()) % (33'(span) + 33'd2));
		endcase
	endfunction

	// random mix: weights for add, extract and find; the rest is mode 3
	task automatic run_mix(int count, int w_add, int w_ext, int w_find);
		int r;
		logic [1:0] md;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_add)
				md = MODE_ADD;
			else if (r < w_add + w_ext)
				md = MODE_EXTRACT;
			else if (r < w_add + w_ext + w_find)
				md = MODE_FIND;
			else
				md = 2'd3;
			send_op(md, pick_id(), pick_score());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		mode = MODE_ADD;
		block_id = 32'd0;
		score = 32'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_MIN;
		pwdata = 32'd0;
		quiet = 1'b0;
		items_sent = 0;
		cur_min = 32'hFFFF_FFFF;
		cur_max = 32'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty queue, unused mode, range extremes under reset registers
		send_op(MODE_EXTRACT, 32'd0, 32'd0);
		send_op(MODE_FIND, 32'hFFFF_FFFF, 32'd0);
		send_op(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(MODE_ADD, 32'd0, 32'hFFFF_FFFF);
		send_op(MODE_ADD, 32'hFFFF_FFFF, 32'd0);
		send_op(MODE_ADD, 32'h0000_0007, 32'd254);
		send_op(MODE_ADD, 32'h0000_0007, 32'hFFFF_FFFE);
		send_op(MODE_ADD, 32'h5555_5555, 32'h8000_0000);
		send_op(MODE_FIND, 32'hFFFF_FFFF, 32'd1);
		send_op(MODE_FIND, 32'h1234_5678, 32'd0);
		send_op(MODE_FIND, 32'h0000_0007, 32'd0);
		send_op(MODE_EXTRACT, 32'd0, 32'd0);
		send_op(MODE_EXTRACT, 32'd0, 32'd0);
		send_op(MODE_EXTRACT, 32'd0, 32'd0);
		send_op(MODE_EXTRACT, 32'd0, 32'd0);
		send_op(MODE_ADD, 32'hAAAA_AAAA, 32'd5);
		send_op(MODE_ADD, 32'hAAAA_AAAA, 32'd5);
		send_op(MODE_FIND, 32'hAAAA_AAAA, 32'd0);
		send_op(MODE_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// random phases over several score ranges
		set_range(32'd0, 32'hFFFF_FFFF);
		run_mix(RANDOM_PER_PHASE, 45, 30, 20);
		quiet = 1'b1;
		set_range(32'd1000, 32'd1000 + 32'd768);
		run_mix(RANDOM_PER_PHASE, 45, 30, 20);
		quiet = 1'b0;
		set_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_mix(RANDOM_PER_PHASE, 50, 25, 20);

		// fill past capacity so adds hit the full case
		set_range(32'd0, 32'd100);
		run_mix(FILL_ITEMS, 99, 0, 0);

		// drain with extracts and finds over a full store
		set_range(32'h8000_0000, 32'h7FFF_FFFF);
		run_mix(RANDOM_PER_PHASE, 10, 60, 28);
		set_range($urandom(), $urandom());
		run_mix(RANDOM_PER_PHASE, 40, 35, 20);
		quiet = 1'b1;
		set_range(32'd0, 32'd0);
		run_mix(RANDOM_PER_PHASE / 2, 40, 40, 15);
		quiet = 1'b0;
		run_mix(RANDOM_PER_PHASE / 2, 40, 40, 15);

		@(negedge clk);
		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Ran %0d operations through 8 score ranges, %0d results checked, %0d full adds.",
			items_sent, results_seen, full_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
